// ----- rtl/core/wres_pkg.sv -----
// ============================================================================
// Weighted random entry select package
// Shared sizes, codes and helper types for the weighted random select core.
// ============================================================================
package wres_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int RATE_W   = 16;
    localparam int TAG_W    = 16;
    localparam int RND_W    = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OUTIDX_W = 4;

    // A total of nonnegative rates is below 2^15 times the table depth.
    localparam int TOTAL_W  = RATE_W - 1 + IDX_W;
    localparam int BITCNT_W = $clog2(RND_W + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_CHOSEN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd3;

    // Table write request.
    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        addr;
        logic [RATE_W-1:0]       rate;
        logic [TAG_W-1:0]        tag;
    } tbl_wr_t;

    // Modulo unit request and response.
    typedef struct packed {
        logic                    start;
        logic [RND_W-1:0]        dividend;
        logic [TOTAL_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [TOTAL_W-1:0]      remainder;
    } div_rsp_t;

    // Keeps the low bits of a table index for the result port.
    function automatic logic [OUTIDX_W-1:0] to_out_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUTIDX_W-1:0] wide;
        wide = {{OUTIDX_W{1'b0}}, idx};
        return wide[OUTIDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/wres_table.sv -----
// ============================================================================
// Entry table
// Rate and tag storage with one write port and one registered read port.
// ============================================================================
module wres_table
(
    input  logic                            clk,
    input  wres_pkg::tbl_wr_t               wr,
    input  logic [wres_pkg::IDX_W-1:0]      rd_addr,
    output logic [wres_pkg::RATE_W-1:0]     rd_rate,
    output logic [wres_pkg::TAG_W-1:0]      rd_tag
);

    logic [wres_pkg::RATE_W-1:0] rate_mem [wres_pkg::MAX_ENTRIES];
    logic [wres_pkg::TAG_W-1:0]  tag_mem  [wres_pkg::MAX_ENTRIES];
    logic [wres_pkg::RATE_W-1:0] rd_rate_reg;
    logic [wres_pkg::TAG_W-1:0]  rd_tag_reg;

    // Storage has no reset; only entries below the fill count are read.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rate_mem[wr.addr] <= wr.rate;
            tag_mem[wr.addr]  <= wr.tag;
        end
        rd_rate_reg <= rate_mem[rd_addr];
        rd_tag_reg  <= tag_mem[rd_addr];
    end

    assign rd_rate = rd_rate_reg;
    assign rd_tag  = rd_tag_reg;

endmodule

// ----- rtl/core/wres_modulo.sv -----
// ============================================================================
// Modulo unit
// Restoring remainder unit that retires one dividend bit per cycle.
// ============================================================================
module wres_modulo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wres_pkg::div_req_t   req,
    output wres_pkg::div_rsp_t   rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [wres_pkg::BITCNT_W-1:0]   cnt_reg, cnt_next;
    logic [wres_pkg::TOTAL_W-1:0]    rem_reg, rem_next;
    logic [wres_pkg::RND_W-1:0]      dvd_reg, dvd_next;
    logic [wres_pkg::TOTAL_W-1:0]    div_reg, div_next;
    logic [wres_pkg::TOTAL_W:0]      shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        shifted   = {rem_reg, dvd_reg[wres_pkg::RND_W-1]};

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = wres_pkg::BITCNT_W'(wres_pkg::RND_W);
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so one subtract suffices.
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = wres_pkg::TOTAL_W'(shifted - {1'b0, div_reg});
            end
            else
            begin
                rem_next = shifted[wres_pkg::TOTAL_W-1:0];
            end
            dvd_next = {dvd_reg[wres_pkg::RND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wres_pkg::BITCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/core/weighted_random_entry_select_core.sv -----
// ============================================================================
// Weighted random entry select core
// Roulette-wheel selection over a small table of rated, tagged entries.
// ============================================================================
// The core holds up to sixteen entries, each a signed rate and a tag. An
// append transaction stores an entry (status FULL when the table is full),
// a clear transaction empties the table, and both answer DONE. A select
// transaction walks the table once to add up the rates of entries that
// pass the optional tag filter; if a matching entry has a negative rate,
// the pick is random_value mod entry count over all entries. Otherwise
// random_value mod the total picks a point on the wheel and a second walk
// finds the entry whose running sum first exceeds it; a zero total answers
// NONE. Each walk reads one entry per cycle from the single read port of
// the table, and the shared modulo unit retires one of the 31 bits of
// random_value per cycle. One transaction is worked on at a time and
// in_stall stays high until its result has moved into the output register;
// that register lets a new transaction enter while the previous result
// still waits behind out_stall.
module weighted_random_entry_select_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wres_pkg::OP_W-1:0]           op,
    input  logic signed [wres_pkg::RATE_W-1:0]  entry_rate,
    input  logic [wres_pkg::TAG_W-1:0]          entry_tag,
    input  logic [wres_pkg::RND_W-1:0]          random_value,
    input  logic                                filter_enable,
    input  logic [wres_pkg::TAG_W-1:0]          filter_tag,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wres_pkg::STATUS_W-1:0]       status,
    output logic [wres_pkg::OUTIDX_W-1:0]       chosen_index
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_PICK,
        S_OUT
    } state_t;

    state_t                               state_reg, state_next;
    logic [wres_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [wres_pkg::CNT_W-1:0]           addr_reg, addr_next;
    logic                                 vld_reg, vld_next;
    logic [wres_pkg::IDX_W-1:0]           vidx_reg, vidx_next;
    logic [wres_pkg::TOTAL_W-1:0]         acc_reg, acc_next;
    logic [wres_pkg::TOTAL_W-1:0]         pick_reg, pick_next;
    logic                                 uniform_reg, uniform_next;
    logic [wres_pkg::RND_W-1:0]           rnd_reg, rnd_next;
    logic                                 filt_reg, filt_next;
    logic [wres_pkg::TAG_W-1:0]           ftag_reg, ftag_next;
    logic [wres_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [wres_pkg::OUTIDX_W-1:0]        res_index_reg, res_index_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [wres_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [wres_pkg::OUTIDX_W-1:0]        chosen_index_reg, chosen_index_next;

    wres_pkg::tbl_wr_t                    tbl_wr;
    logic [wres_pkg::RATE_W-1:0]          rd_rate;
    logic [wres_pkg::TAG_W-1:0]           rd_tag;
    wres_pkg::div_req_t                   div_req;
    wres_pkg::div_rsp_t                   div_rsp;

    logic                                 accept;
    logic                                 match;
    logic [wres_pkg::TOTAL_W-1:0]         rate_mag;
    logic [wres_pkg::TOTAL_W-1:0]         acc_sum;
    logic                                 walk_end;
    logic                                 out_free;

    wres_table u_table
    (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (addr_reg[wres_pkg::IDX_W-1:0]),
        .rd_rate (rd_rate),
        .rd_tag  (rd_tag)
    );

    wres_modulo u_modulo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // Entry read in the previous cycle, as seen by both walks.
    assign match    = !filt_reg || (rd_tag == ftag_reg);
    assign rate_mag = {{(wres_pkg::TOTAL_W-wres_pkg::RATE_W+1){1'b0}},
                       rd_rate[wres_pkg::RATE_W-2:0]};
    assign acc_sum  = acc_reg + rate_mag;
    // All reads issued and the last one consumed.
    assign walk_end = !vld_reg && (addr_reg >= count_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        addr_next         = addr_reg;
        vld_next          = 1'b0;
        vidx_next         = vidx_reg;
        acc_next          = acc_reg;
        pick_next         = pick_reg;
        uniform_next      = uniform_reg;
        rnd_next          = rnd_reg;
        filt_next         = filt_reg;
        ftag_next         = ftag_reg;
        res_status_next   = res_status_reg;
        res_index_next    = res_index_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        chosen_index_next = chosen_index_reg;

        tbl_wr.en         = 1'b0;
        tbl_wr.addr       = count_reg[wres_pkg::IDX_W-1:0];
        tbl_wr.rate       = $unsigned(entry_rate);
        tbl_wr.tag        = entry_tag;

        div_req.start     = 1'b0;
        div_req.dividend  = rnd_reg;
        div_req.divisor   = acc_reg;

        // Read issue for both walks: one entry per cycle below the count.
        if ((state_reg == S_SUM) || (state_reg == S_PICK))
        begin
            if (addr_reg < count_reg)
            begin
                vld_next  = 1'b1;
                vidx_next = addr_reg[wres_pkg::IDX_W-1:0];
                addr_next = addr_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rnd_next        = random_value;
                    filt_next       = filter_enable;
                    ftag_next       = filter_tag;
                    res_index_next  = '0;
                    res_status_next = wres_pkg::ST_NONE;
                    state_next      = S_OUT;
                    case (op)
                        wres_pkg::OP_APPEND:
                        begin
                            if (count_reg == wres_pkg::CNT_W'(wres_pkg::MAX_ENTRIES))
                            begin
                                res_status_next = wres_pkg::ST_FULL;
                            end
                            else
                            begin
                                tbl_wr.en       = 1'b1;
                                count_next      = count_reg + 1'b1;
                                res_status_next = wres_pkg::ST_DONE;
                            end
                        end
                        wres_pkg::OP_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = wres_pkg::ST_DONE;
                        end
                        wres_pkg::OP_SELECT:
                        begin
                            if (count_reg != '0)
                            begin
                                addr_next  = '0;
                                acc_next   = '0;
                                state_next = S_SUM;
                            end
                        end
                        default:
                        begin
                            res_status_next = wres_pkg::ST_NONE;
                        end
                    endcase
                end
            end

            S_SUM:
            begin
                if (vld_reg && match && rd_rate[wres_pkg::RATE_W-1])
                begin
                    // A negative rate switches to a uniform pick over all entries.
                    uniform_next     = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.divisor  = {{(wres_pkg::TOTAL_W-wres_pkg::CNT_W){1'b0}}, count_reg};
                    vld_next         = 1'b0;
                    state_next       = S_DIV;
                end
                else if (vld_reg)
                begin
                    if (match)
                    begin
                        acc_next = acc_sum;
                    end
                end
                else if (walk_end)
                begin
                    if (acc_reg == '0)
                    begin
                        res_status_next = wres_pkg::ST_NONE;
                        res_index_next  = '0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        uniform_next  = 1'b0;
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (uniform_reg)
                    begin
                        res_status_next = wres_pkg::ST_CHOSEN;
                        res_index_next  = div_rsp.remainder[wres_pkg::OUTIDX_W-1:0];
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        pick_next  = div_rsp.remainder;
                        addr_next  = '0;
                        acc_next   = '0;
                        state_next = S_PICK;
                    end
                end
            end

            S_PICK:
            begin
                if (vld_reg)
                begin
                    if (match && !rd_rate[wres_pkg::RATE_W-1] && (rd_rate != '0))
                    begin
                        acc_next = acc_sum;
                        if (pick_reg < acc_sum)
                        begin
                            res_status_next = wres_pkg::ST_CHOSEN;
                            res_index_next  = wres_pkg::to_out_index(vidx_reg);
                            vld_next        = 1'b0;
                            state_next      = S_OUT;
                        end
                    end
                end
                else if (walk_end)
                begin
                    res_status_next = wres_pkg::ST_NONE;
                    res_index_next  = '0;
                    state_next      = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    chosen_index_next = res_index_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            vld_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            chosen_index_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            vld_reg          <= vld_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            chosen_index_reg <= chosen_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        vidx_reg         <= vidx_next;
        acc_reg          <= acc_next;
        pick_reg         <= pick_next;
        uniform_reg      <= uniform_next;
        rnd_reg          <= rnd_next;
        filt_reg         <= filt_next;
        ftag_reg         <= ftag_next;
        res_status_reg   <= res_status_next;
        res_index_reg    <= res_index_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_index_reg;

endmodule

// ----- tb/weighted_random_entry_select_core_test.sv -----
// ============================================================================
// Weighted random entry select core testbench
// Drives append, select, clear and unused-code transactions into the core with random
// gaps on the input side and random stalls on the result side. A predictor
// kept in this file tracks the entry table and works out the status and
// index of every accepted transaction. A monitor compares each result with
// the oldest prediction.
// ============================================================================
module weighted_random_entry_select_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wres_pkg::*;

    // The package names only the three operations in use. The fourth code
    // must be ignored by the core and answered with NONE.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    // The last transactions run with no gaps and no stalls at all.
    localparam int CALM_TAIL    = 150;
    // This tail leaves room for any stray result to show up after the last
    // expected one.
    localparam int TAIL_CYCLES  = 200;
    // Slowest correct run: about 1200 transactions, each with its work plus
    // an input gap and an output stall; the limit is several times that.
    localparam int CYCLE_LIMIT  = 600000;

    // One input transaction.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [RATE_W-1:0] rate;
        logic [TAG_W-1:0]         tag;
        logic [RND_W-1:0]         draw;
        logic                     filt;
        logic [TAG_W-1:0]         ftag;
    } wheel_req_t;

    // One result transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUTIDX_W-1:0] index;
    } wheel_ans_t;

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op            = '0;
    logic signed [RATE_W-1:0] entry_rate    = '0;
    logic [TAG_W-1:0]         entry_tag     = '0;
    logic [RND_W-1:0]         random_value  = '0;
    logic                     filter_enable = 1'b0;
    logic [TAG_W-1:0]         filter_tag    = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [OUTIDX_W-1:0]      chosen_index;

    // Transactions waiting to be driven, and predictions waiting for results.
    wheel_req_t pending_reqs[$];
    wheel_ans_t expected_answers[$];

    // The predictor's own copy of the entry table.
    logic signed [RATE_W-1:0] shadow_rate [MAX_ENTRIES];
    logic [TAG_W-1:0]         shadow_tag  [MAX_ENTRIES];
    int unsigned              shadow_count = 0;

    // Set once the end of the stimulus is near; both sides stop idling then.
    logic calm = 1'b0;

    int          item_goal    = 0;
    int          accepted_cnt = 0;
    int          err_cnt      = 0;
    int unsigned cycle_cnt    = 0;

    weighted_random_entry_select_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .entry_rate    (entry_rate),
        .entry_tag     (entry_tag),
        .random_value  (random_value),
        .filter_enable (filter_enable),
        .filter_tag    (filter_tag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .chosen_index  (chosen_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Applies one transaction to the shadow table and returns its answer.
    // A select first adds up the rates of the entries that pass the filter;
    // the first passing entry with a negative rate switches to a uniform
    // pick over every stored entry, filter or not. Otherwise the draw is
    // reduced mod the total and a second walk over the passing entries with
    // a positive rate finds the first whose running sum exceeds that point.
    function automatic wheel_ans_t spin_wheel(input wheel_req_t req);
        wheel_ans_t  ans;
        int unsigned n;
        int unsigned total;
        int unsigned point;
        int unsigned run_sum;
        bit          uniform;

        ans.status = ST_NONE;
        ans.index  = '0;
        n          = shadow_count;
        total      = 0;
        run_sum    = 0;
        uniform    = 1'b0;
        case (req.op)
            OP_APPEND:
            begin
                if (n >= MAX_ENTRIES)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    shadow_rate[n] = req.rate;
                    shadow_tag[n]  = req.tag;
                    shadow_count   = n + 1;
                    ans.status     = ST_DONE;
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                ans.status   = ST_DONE;
            end
            OP_SELECT:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (req.filt && shadow_tag[i] != req.ftag)
                        continue;
                    if (shadow_rate[i] < 0)
                    begin
                        uniform = 1'b1;
                        break;
                    end
                    total += int'(shadow_rate[i]);
                end
                if (uniform)
                begin
                    ans.status = ST_CHOSEN;
                    ans.index  = OUTIDX_W'(req.draw % n);
                end
                else if (total != 0)
                begin
                    point = req.draw % total;
                    for (int i = 0; i < n; i++)
                    begin
                        if (req.filt && shadow_tag[i] != req.ftag)
                            continue;
                        if (shadow_rate[i] <= 0)
                            continue;
                        run_sum += int'(shadow_rate[i]);
                        if (point < run_sum)
                        begin
                            ans.status = ST_CHOSEN;
                            ans.index  = OUTIDX_W'(i);
                            break;
                        end
                    end
                end
            end
            default:
            begin
                ans.status = ST_NONE;
            end
        endcase
        return ans;
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] kind, input logic signed [RATE_W-1:0] rate,
                             input logic [TAG_W-1:0] tag, input logic [RND_W-1:0] draw,
                             input logic filt, input logic [TAG_W-1:0] ftag);
        wheel_req_t req;
        req = '{op: kind, rate: rate, tag: tag, draw: draw, filt: filt, ftag: ftag};
        pending_reqs = {pending_reqs, req};
    endtask

    // Rates lean toward small weights so that the wheel spreads over several
    // entries; zeros and negatives show up now and then.
    function automatic logic signed [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 19))
            0:       return {1'b1, 15'($urandom())};
            1, 2:    return '0;
            3:       return 16'sh7FFF;
            4, 5, 6, 7, 8, 9, 10, 11:
                     return RATE_W'($urandom_range(1, 20));
            default: return RATE_W'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [RND_W-1:0] pick_draw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RND_W'($urandom_range(0, 100));
            default: return RND_W'($urandom());
        endcase
    endfunction

    // Driver: holds a transaction on the input ports until it is accepted,
    // then takes the next one from the pending queue, sometimes after a gap.
    // The prediction is made at the edge where the core accepts.
    always @(posedge clk)
    begin : drive
        static wheel_req_t cur_req;
        static int         gap_left = 0;
        bit                took;

        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                expected_answers = {expected_answers, spin_wheel(cur_req)};
                accepted_cnt++;
            end
            if (took || !in_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    // A gap: this idle turn plus gap_left more.
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_req = pending_reqs.pop_front();
                    op            <= cur_req.op;
                    entry_rate    <= cur_req.rate;
                    entry_tag     <= cur_req.tag;
                    random_value  <= cur_req.draw;
                    filter_enable <= cur_req.filt;
                    filter_tag    <= cur_req.ftag;
                    in_valid      <= 1'b1;
                end
            end
            calm <= (pending_reqs.size() < CALM_TAIL);
        end
    end

    // Monitor: checks every accepted result against the oldest prediction
    // and stalls the result side in random bursts.
    always @(posedge clk)
    begin : watch
        static int  stall_left = 0;
        wheel_ans_t want;

        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("result with nothing expected, status", status, 'x);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (chosen_index !== want.index)
                        report_mismatch("chosen_index", chosen_index, want.index);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("weighted_random_entry_select_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TAG_W-1:0] tag_pool [3];
        int               gen_count;
        int               kind;

        gen_count = 0;

        // Directed part. Selecting from an empty table and the unused
        // operation both answer NONE.
        queue_req(OP_SELECT, '0, '0, '1, 1'b0, '0);
        queue_req(OP_UNUSED, '1, '1, '1, 1'b1, '1);
        // A single zero-rate entry gives a zero total.
        queue_req(OP_APPEND, '0, '0, '0, 1'b0, '0);
        queue_req(OP_SELECT, '0, '0, '1, 1'b0, '0);
        // The largest rate with the largest tag, then the most negative rate.
        queue_req(OP_APPEND, 16'sh7FFF, 16'hFFFF, '0, 1'b0, '0);
        queue_req(OP_APPEND, -16'sh8000, 16'h8000, '0, 1'b0, '0);
        // The filter hides the negative entry, so the wheel is weighted.
        queue_req(OP_SELECT, '0, '0, '1, 1'b1, 16'hFFFF);
        // A negative entry that passes the filter makes the pick uniform
        // over all entries, whatever their tags.
        queue_req(OP_SELECT, '0, '0, 31'h5555_5555, 1'b1, 16'h8000);
        queue_req(OP_SELECT, '0, '0, 31'h2AAA_AAAA, 1'b0, '0);
        // No entry carries this tag.
        queue_req(OP_SELECT, '0, '0, '1, 1'b1, 16'h1357);
        // Fill the table to the top, then one append too many.
        for (int i = 0; i < 13; i++)
            queue_req(OP_APPEND, RATE_W'(1000 * (i + 1)), i[0] ? 16'h00FF : 16'h0100,
                      '0, 1'b0, '0);
        queue_req(OP_APPEND, 16'sh0001, 16'h00FF, '0, 1'b0, '0);
        // A filter that matches only some positive entries on a full table.
        queue_req(OP_SELECT, '0, '0, '1, 1'b1, 16'h00FF);
        queue_req(OP_CLEAR, '0, '0, '0, 1'b0, '0);
        gen_count = 0;

        item_goal = pending_reqs.size() + RANDOM_ITEMS;

        // Random part: mostly a fill of a few entries followed by selects
        // against it, with noise and empty-table selects mixed in.
        while (pending_reqs.size() < item_goal)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 7)
            begin
                if (gen_count >= 12 || $urandom_range(0, 1) == 1)
                begin
                    queue_req(OP_CLEAR, pick_rate(), TAG_W'($urandom()), pick_draw(),
                              1'($urandom()), TAG_W'($urandom()));
                    gen_count = 0;
                end
                foreach (tag_pool[k])
                    tag_pool[k] = TAG_W'($urandom());
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(13, 18)
                                                    : $urandom_range(1, 8))
                begin
                    queue_req(OP_APPEND, pick_rate(), tag_pool[$urandom_range(0, 2)],
                              pick_draw(), 1'($urandom()), TAG_W'($urandom()));
                    gen_count++;
                end
                repeat ($urandom_range(2, 8))
                    queue_req(OP_SELECT, pick_rate(), TAG_W'($urandom()), pick_draw(),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 4) == 0) ? TAG_W'($urandom())
                                                          : tag_pool[$urandom_range(0, 2)]);
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_req(OP_W'($urandom_range(0, 3)), RATE_W'($urandom()),
                              TAG_W'($urandom()), RND_W'($urandom()), 1'($urandom()),
                              TAG_W'($urandom()));
                    if (pending_reqs[$].op == OP_APPEND)
                        gen_count++;
                    else if (pending_reqs[$].op == OP_CLEAR)
                        gen_count = 0;
                end
            end
            else
            begin
                queue_req(OP_CLEAR, RATE_W'($urandom()), TAG_W'($urandom()),
                          RND_W'($urandom()), 1'($urandom()), TAG_W'($urandom()));
                gen_count = 0;
                repeat ($urandom_range(1, 3))
                    queue_req(($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_SELECT,
                              RATE_W'($urandom()), TAG_W'($urandom()), pick_draw(),
                              1'($urandom()), TAG_W'($urandom()));
            end
        end
        item_goal = pending_reqs.size();

        // Hold reset, then release it once.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < item_goal)
            @(negedge clk);
        while (expected_answers.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_cnt == 0)
            $display("weighted_random_entry_select_core_test OK");
        else
            $display("weighted_random_entry_select_core_test NOT OK");
        $finish;
    end

endmodule
